>>> rtl/fdrp_pkg.sv
package fdrp_pkg;

  localparam int unsigned PAL_IDX_W     = 3;
  localparam int unsigned COLOR_W       = 12;
  localparam int unsigned ROW_W         = 16;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TRIPLE_LAST   = 2;
  localparam int unsigned REPEAT_BIAS   = 2;

  localparam int unsigned FL_REPEAT_BIT   = 0;
  localparam int unsigned FL_DUP_BIT      = 1;
  localparam int unsigned FL_NOCOMMON_BIT = 2;
  localparam int unsigned FL_INC_BIT      = 3;
  localparam int unsigned FL_COMPACT_BIT  = 4;

  localparam logic        KIND_PALETTE = 1'b0;
  localparam logic        KIND_RECORD  = 1'b1;

  typedef enum logic [6:0] {
    PH_PALETTE = 7'b0000001,
    PH_FLAGS   = 7'b0000010,
    PH_ROW_LO  = 7'b0000100,
    PH_ROW_HI  = 7'b0001000,
    PH_COMMON  = 7'b0010000,
    PH_LEN     = 7'b0100000,
    PH_REPEAT  = 7'b1000000
  } fdrp_phase_e;

  typedef struct packed {
    fdrp_phase_e          phase;
    logic [1:0]           pal_pos;
    logic [PAL_IDX_W-1:0] pal_idx;
    logic [BYTE_W-1:0]    partial;
    logic [BYTE_W-1:0]    flags;
    logic [ROW_W-1:0]     row;
    logic [BYTE_W-1:0]    row_lo;
    logic [BYTE_W-1:0]    common;
    logic [BYTE_W-1:0]    length;
  } fdrp_parse_t;

  typedef struct packed {
    logic                 kind;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [COLOR_W-1:0]   color_rgb12;
    logic [ROW_W-1:0]     first_row;
    logic [COUNT_W-1:0]   row_count;
    logic                 row_step;
    logic [BYTE_W-1:0]    common_pixels;
    logic [BYTE_W-1:0]    row_length;
    logic [BYTE_W-1:0]    offset_stride;
  } fdrp_result_t;

endpackage

>>> rtl/fdrp_in_if.sv
interface fdrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       video_restart;

  modport source (output valid, data_byte, frame_start, video_restart, input ready);
  modport sink   (input valid, data_byte, frame_start, video_restart, output ready);
endinterface

>>> rtl/fdrp_out_if.sv
interface fdrp_out_if #(
  parameter int unsigned OFFSET_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [2:0]             palette_index;
  logic [11:0]            color_rgb12;
  logic [15:0]            first_row;
  logic [8:0]             row_count;
  logic                   row_step;
  logic [7:0]             common_pixels;
  logic [7:0]             row_length;
  logic [OFFSET_BITS-1:0] source_offset;
  logic [7:0]             offset_stride;

  modport source (
    output valid, kind, palette_index, color_rgb12, first_row, row_count, row_step,
           common_pixels, row_length, source_offset, offset_stride,
    input  ready
  );
  modport sink (
    input  valid, kind, palette_index, color_rgb12, first_row, row_count, row_step,
           common_pixels, row_length, source_offset, offset_stride,
    output ready
  );
endinterface

>>> rtl/frame_delta_row_parser.sv
// Channel | Dir | Payload                                                   | Handshake
// in_i    | in  | data_byte, frame_start, video_restart                     | valid/ready
// out_o   | out | kind, palette_index, color_rgb12, first_row, row_count,  | valid/ready
//         |     | row_step, common_pixels, row_length, source_offset,      |
//         |     | offset_stride                                             |
// One byte per cycle sustained while out_o is not stalled.
// The byte lands in an input register, then one pass of parser logic updates the
// state and loads the result register; the 9x8 repeat-length product sets the path.
// A byte that makes no result still waits for a free result register.
// rst_ni clears the input and result valid flags and puts the parser in palette phase.
// With out_o stalled, one byte is held in the input register and in_i.ready drops.
module frame_delta_row_parser #(
  parameter int unsigned PALETTE_ENTRIES = 8,
  parameter int unsigned OFFSET_BITS     = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fdrp_in_if.sink         in_i,
  fdrp_out_if.source      out_o
);
  import fdrp_pkg::*;

  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   s1_fs_q;
  logic                   s1_vr_q;
  logic                   advance;

  fdrp_parse_t            parse_q;
  fdrp_parse_t            parse_d;
  logic [OFFSET_BITS-1:0] next_off_q;
  logic [OFFSET_BITS-1:0] next_off_d;
  logic [OFFSET_BITS-1:0] prev_off_q;
  logic [OFFSET_BITS-1:0] prev_off_d;

  logic                   step_emit;
  fdrp_result_t           step_res;
  logic [OFFSET_BITS-1:0] step_src;

  logic                   out_valid_q;
  logic                   out_valid_d;
  fdrp_result_t           res_q;
  logic [OFFSET_BITS-1:0] src_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_fs_q   <= in_i.frame_start;
      s1_vr_q   <= in_i.video_restart;
    end
  end

  fdrp_step #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_step (
    .parse_i         (parse_q),
    .next_off_i      (next_off_q),
    .prev_off_i      (prev_off_q),
    .data_byte_i     (s1_byte_q),
    .frame_start_i   (s1_fs_q),
    .video_restart_i (s1_vr_q),
    .parse_o         (parse_d),
    .next_off_o      (next_off_d),
    .prev_off_o      (prev_off_d),
    .emit_o          (step_emit),
    .result_o        (step_res),
    .source_offset_o (step_src)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q       <= '0;
      parse_q.phase <= PH_PALETTE;
      parse_q.row   <= '1;
      next_off_q    <= '0;
      prev_off_q    <= '0;
    end else if (advance) begin
      parse_q    <= parse_d;
      next_off_q <= next_off_d;
      prev_off_q <= prev_off_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step_emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_emit) begin
      res_q <= step_res;
      src_q <= step_src;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.palette_index = res_q.palette_index;
  assign out_o.color_rgb12   = res_q.color_rgb12;
  assign out_o.first_row     = res_q.first_row;
  assign out_o.row_count     = res_q.row_count;
  assign out_o.row_step      = res_q.row_step;
  assign out_o.common_pixels = res_q.common_pixels;
  assign out_o.row_length    = res_q.row_length;
  assign out_o.source_offset = src_q;
  assign out_o.offset_stride = res_q.offset_stride;

  a_frame_start_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_fs_q |=> parse_q.phase == PH_PALETTE && parse_q.pal_pos == 2'd1)
    else $error("frame start did not restart palette parsing");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_vr_q && !(step_emit && step_res.kind == KIND_RECORD)
    |=> next_off_q == '0 && prev_off_q == '0)
    else $error("restart left running offsets set");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input transaction lost");

  a_record_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.kind == KIND_RECORD |-> out_o.row_count != '0)
    else $error("record result with zero repeat count");

  a_palette_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.kind == KIND_PALETTE
    |-> out_o.row_count == '0 && out_o.source_offset == '0 && out_o.first_row == '0)
    else $error("palette result carries record fields");

endmodule

>>> rtl/fdrp_step.sv
module fdrp_step #(
  parameter int unsigned PALETTE_ENTRIES = 8,
  parameter int unsigned OFFSET_BITS     = 32
) (
  input  fdrp_pkg::fdrp_parse_t  parse_i,
  input  logic [OFFSET_BITS-1:0] next_off_i,
  input  logic [OFFSET_BITS-1:0] prev_off_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_start_i,
  input  logic                   video_restart_i,
  output fdrp_pkg::fdrp_parse_t  parse_o,
  output logic [OFFSET_BITS-1:0] next_off_o,
  output logic [OFFSET_BITS-1:0] prev_off_o,
  output logic                   emit_o,
  output fdrp_pkg::fdrp_result_t result_o,
  output logic [OFFSET_BITS-1:0] source_offset_o
);
  import fdrp_pkg::*;

  localparam int unsigned SUM_W = OFFSET_BITS + 17;
  localparam logic [PAL_IDX_W-1:0] LAST_IDX = PAL_IDX_W'(PALETTE_ENTRIES - 1);

  function automatic fdrp_phase_e after_phase(fdrp_phase_e ph, logic [7:0] fl);
    fdrp_phase_e r;
    r = PH_FLAGS;
    unique case (ph)
      PH_FLAGS: begin
        if (!fl[FL_INC_BIT])           r = PH_ROW_LO;
        else if (!fl[FL_NOCOMMON_BIT]) r = PH_COMMON;
        else if (!fl[FL_COMPACT_BIT])  r = PH_LEN;
        else if (fl[FL_REPEAT_BIT])    r = PH_REPEAT;
      end
      PH_ROW_LO: r = PH_ROW_HI;
      PH_ROW_HI: begin
        if (!fl[FL_NOCOMMON_BIT])      r = PH_COMMON;
        else if (!fl[FL_COMPACT_BIT])  r = PH_LEN;
        else if (fl[FL_REPEAT_BIT])    r = PH_REPEAT;
      end
      PH_COMMON: begin
        if (!fl[FL_COMPACT_BIT])       r = PH_LEN;
        else if (fl[FL_REPEAT_BIT])    r = PH_REPEAT;
      end
      PH_LEN: begin
        if (fl[FL_REPEAT_BIT])         r = PH_REPEAT;
      end
      default: r = PH_FLAGS;
    endcase
    return r;
  endfunction

  fdrp_parse_t            ps;
  logic [3:0]             nib;
  logic                   rec_done;
  logic [7:0]             rep;
  logic [COUNT_W-1:0]     cnt;
  logic [COUNT_W-1:0]     cnt_m1;
  logic [16:0]            prod_prev;
  logic [16:0]            prod_next;
  logic [OFFSET_BITS-1:0] src;
  logic [SUM_W-1:0]       sum_prev;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       sum_dup;
  logic                   inc;
  logic                   dup;

  assign nib = data_byte_i[7:4];

  always_comb begin
    ps         = parse_i;
    next_off_o = next_off_i;
    prev_off_o = prev_off_i;
    emit_o     = 1'b0;
    result_o   = '0;
    rec_done   = 1'b0;
    rep        = '0;

    if (video_restart_i) begin
      next_off_o = '0;
      prev_off_o = '0;
    end
    if (frame_start_i) begin
      ps.phase   = PH_PALETTE;
      ps.pal_pos = '0;
      ps.pal_idx = '0;
      ps.partial = '0;
      ps.row     = '1;
    end

    unique case (ps.phase)
      PH_PALETTE: begin
        case (ps.pal_pos)
          2'd0:    ps.partial = {nib, 4'h0};
          2'd1:    ps.partial = ps.partial | {4'h0, nib};
          default: begin
            emit_o                 = 1'b1;
            result_o.kind          = KIND_PALETTE;
            result_o.palette_index = ps.pal_idx;
            result_o.color_rgb12   = {ps.partial, nib};
          end
        endcase
        if (ps.pal_pos == 2'(TRIPLE_LAST)) begin
          ps.pal_pos = '0;
          if (ps.pal_idx == LAST_IDX) begin
            ps.pal_idx = '0;
            ps.phase   = PH_FLAGS;
          end else begin
            ps.pal_idx = ps.pal_idx + PAL_IDX_W'(1);
          end
        end else begin
          ps.pal_pos = ps.pal_pos + 2'd1;
        end
      end
      PH_FLAGS: begin
        ps.flags  = data_byte_i;
        ps.common = '0;
        ps.length = data_byte_i[FL_COMPACT_BIT] ? 8'({data_byte_i[7:5]}) + 8'd1 : 8'd0;
        ps.phase  = after_phase(PH_FLAGS, data_byte_i);
        rec_done  = (ps.phase == PH_FLAGS);
      end
      PH_ROW_LO: begin
        ps.row_lo = data_byte_i;
        ps.phase  = after_phase(PH_ROW_LO, ps.flags);
      end
      PH_ROW_HI: begin
        ps.row   = {data_byte_i, ps.row_lo};
        ps.phase = after_phase(PH_ROW_HI, ps.flags);
        rec_done = (ps.phase == PH_FLAGS);
      end
      PH_COMMON: begin
        ps.common = data_byte_i;
        ps.phase  = after_phase(PH_COMMON, ps.flags);
        rec_done  = (ps.phase == PH_FLAGS);
      end
      PH_LEN: begin
        ps.length = data_byte_i;
        ps.phase  = after_phase(PH_LEN, ps.flags);
        rec_done  = (ps.phase == PH_FLAGS);
      end
      PH_REPEAT: begin
        rep      = data_byte_i;
        rec_done = 1'b1;
        ps.phase = PH_FLAGS;
      end
      default: ps.phase = PH_FLAGS;
    endcase

    inc       = ps.flags[FL_INC_BIT];
    dup       = ps.flags[FL_DUP_BIT];
    cnt       = ps.flags[FL_REPEAT_BIT] ? COUNT_W'(rep) + COUNT_W'(REPEAT_BIAS) : COUNT_W'(1);
    cnt_m1    = cnt - COUNT_W'(1);
    prod_prev = {8'h00, cnt_m1} * {9'h000, ps.length};
    prod_next = prod_prev + {9'h000, ps.length};
    src       = dup ? prev_off_o : next_off_o;
    sum_prev  = SUM_W'(src) + SUM_W'(prod_prev);
    sum_next  = SUM_W'(src) + SUM_W'(prod_next);
    sum_dup   = SUM_W'(src) + SUM_W'(ps.length);

    source_offset_o = '0;
    if (rec_done) begin
      emit_o                 = 1'b1;
      result_o.kind          = KIND_RECORD;
      result_o.first_row     = inc ? ps.row + ROW_W'(1) : ps.row;
      result_o.row_count     = cnt;
      result_o.row_step      = inc;
      result_o.common_pixels = ps.common;
      result_o.row_length    = ps.length;
      result_o.offset_stride = dup ? 8'd0 : ps.length;
      source_offset_o        = src;
      if (inc) begin
        ps.row = ps.row + ROW_W'(cnt);
      end
      if (dup) begin
        next_off_o = sum_dup[OFFSET_BITS-1:0];
      end else begin
        prev_off_o = sum_prev[OFFSET_BITS-1:0];
        next_off_o = sum_next[OFFSET_BITS-1:0];
      end
    end

    parse_o = ps;
  end

endmodule
